// ===== rtl/adm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the arcade drive mixer
// no dependencies: every other file of the block imports this package

package adm_pkg;

  // output fixed point
  localparam int FracBits = 8;
  localparam int OutW     = 16;

  // field and datapath widths
  localparam int InW      = 8;
  localparam int DzW      = 7;
  localparam int RateW    = 9;
  localparam int KW       = 13;   // 2048 + 10 * rating
  localparam int WeightW  = 14;   // signed axis weights
  localparam int ProdW    = 22;   // reading times weight
  localparam int AxisW    = 22;   // smoothed axis over 5120
  localparam int MixW     = 23;   // forward plus or minus turn
  localparam int MagW     = 22;   // magnitude, divisor and partial remainder
  localparam int NormBits = 16;   // fraction bits of the normalized power
  localparam int QuotW    = NormBits + 1;
  localparam int DvdW     = MagW + QuotW;
  localparam int N2W      = 2 * NormBits + 1;
  localparam int CW       = NormBits + 2;
  localparam int PolyW    = 3 * NormBits + 1;
  localparam int ShiftAmt = 3 * NormBits - FracBits;
  localparam int RoundBit = ShiftAmt - 1;
  localparam int SumW     = ShiftAmt + OutW;

  localparam int Lanes     = 2;
  localparam int LaneLeft  = 0;
  localparam int LaneRight = 1;

  // arithmetic constants
  localparam logic [MagW-1:0]  DenMin   = MagW'(100 * 5120);
  localparam logic [QuotW-1:0] QuotMax  = QuotW'(1) << NormBits;
  localparam logic [CW-1:0]    CurveK   = CW'(3) << NormBits;
  localparam logic [SumW-1:0]  PctScale = SumW'(100);
  localparam logic [SumW-1:0]  RoundVal = SumW'(1) << RoundBit;

  // configuration registers
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CfgDeadZone   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTurnRating = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFwdRating  = 2'd2;

  localparam logic [DzW-1:0]   DeadZoneRst = 7'd5;
  localparam logic [RateW-1:0] RatingRst   = 9'd128;

  typedef struct packed {
    logic signed [InW-1:0] turn_now;
    logic signed [InW-1:0] turn_prev;
    logic signed [InW-1:0] forward_now;
    logic signed [InW-1:0] forward_prev;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] front_left_power;
    logic signed [OutW-1:0] front_right_power;
    logic signed [OutW-1:0] back_left_power;
    logic signed [OutW-1:0] back_right_power;
  } out_t;

  typedef struct packed {
    logic signed [AxisW-1:0] turn;
    logic signed [AxisW-1:0] fwd;
  } axes_t;

  typedef struct packed {
    logic             neg;
    logic [MagW-1:0]  rem;
    logic [QuotW-1:0] lq;    // low dividend bits shift out, quotient bits shift in
  } div_lane_t;

  typedef struct packed {
    logic [MagW-1:0]             den;
    div_lane_t [Lanes-1:0]       lane;
  } div_state_t;

endpackage

// ===== rtl/adm_smooth.sv =====
`timescale 1ns / 1ps
// axis smoothing: dead zone test, weighting and sum, two register stages
// depends on adm_pkg

module adm_smooth import adm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  in_t              data_i,
  input  logic [DzW-1:0]   dead_zone_i,
  input  logic [RateW-1:0] turn_rating_i,
  input  logic [RateW-1:0] forward_rating_i,
  output logic             valid_o,
  output axes_t            data_o
);

  logic signed [InW-1:0]     now_s  [Lanes];
  logic signed [InW-1:0]     prev_s [Lanes];
  logic [RateW-1:0]          rate   [Lanes];
  logic [InW-1:0]            now_mag[Lanes];
  logic                      released[Lanes];
  logic [KW-1:0]             k      [Lanes];
  logic signed [WeightW-1:0] wn     [Lanes];
  logic signed [WeightW-1:0] wp     [Lanes];
  logic signed [ProdW-1:0]   pn_d   [Lanes];
  logic signed [ProdW-1:0]   pp_d   [Lanes];
  logic signed [ProdW-1:0]   pn_q   [Lanes];
  logic signed [ProdW-1:0]   pp_q   [Lanes];
  logic                      v1_q, v2_q;
  axes_t                     axes_d, axes_q;

  // lane 0 is the turn axis, lane 1 the forward axis
  assign now_s[0]  = data_i.turn_now;
  assign prev_s[0] = data_i.turn_prev;
  assign rate[0]   = turn_rating_i;
  assign now_s[1]  = data_i.forward_now;
  assign prev_s[1] = data_i.forward_prev;
  assign rate[1]   = forward_rating_i;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      now_mag[i]  = now_s[i][InW-1] ? InW'(-now_s[i]) : InW'(now_s[i]);
      released[i] = now_mag[i] <= {1'b0, dead_zone_i};
      k[i]        = KW'(2048) + {1'b0, rate[i], 3'b000} + {3'b000, rate[i], 1'b0};
      if (released[i]) begin
        // only the previous reading counts, weighted 1536 - 4 * rating
        wn[i] = '0;
        wp[i] = WeightW'(WeightW'(1536) - {3'b000, rate[i], 2'b00});
      end else begin
        wn[i] = WeightW'({1'b0, k[i]});
        wp[i] = WeightW'(WeightW'(5120) - {1'b0, k[i]});
      end
      pn_d[i] = now_s[i] * wn[i];
      pp_d[i] = prev_s[i] * wp[i];
    end
  end

  assign axes_d.turn = pn_q[0] + pp_q[0];
  assign axes_d.fwd  = pn_q[1] + pp_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pn_q   <= pn_d;
      pp_q   <= pp_d;
      axes_q <= axes_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = axes_q;

endmodule

// ===== rtl/adm_mix.sv =====
`timescale 1ns / 1ps
// wheel mixing, magnitudes, divisor choice and dividend setup, four stages
// depends on adm_pkg

module adm_mix import adm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  axes_t      data_i,
  output logic       valid_o,
  output div_state_t data_o
);

  logic signed [MixW-1:0] side_d[Lanes];
  logic signed [MixW-1:0] side_q[Lanes];
  logic [MagW-1:0]        mag_d [Lanes];
  logic [MagW-1:0]        mag4_q[Lanes];
  logic                   neg4_q[Lanes];
  logic [MagW-1:0]        mag5_q[Lanes];
  logic                   neg5_q[Lanes];
  logic [MagW-1:0]        big;
  logic [MagW-1:0]        den_d, den5_q;
  logic [DvdW-1:0]        dvd   [Lanes];
  div_state_t             st_d, st_q;
  logic                   v3_q, v4_q, v5_q, v6_q;

  assign side_d[LaneLeft]  = {data_i.fwd[AxisW-1], data_i.fwd}
                           + {data_i.turn[AxisW-1], data_i.turn};
  assign side_d[LaneRight] = {data_i.fwd[AxisW-1], data_i.fwd}
                           - {data_i.turn[AxisW-1], data_i.turn};

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      mag_d[l] = side_q[l][MixW-1] ? MagW'(-side_q[l]) : MagW'(side_q[l]);
    end
  end

  // divisor is the largest magnitude, but never below full scale
  assign big   = (mag4_q[LaneRight] > mag4_q[LaneLeft]) ? mag4_q[LaneRight] : mag4_q[LaneLeft];
  assign den_d = (big > DenMin) ? big : DenMin;

  always_comb begin
    st_d.den = den5_q;
    for (int l = 0; l < Lanes; l++) begin
      // rounded dividend: magnitude scaled to the normalized fraction plus half the divisor
      dvd[l] = DvdW'({mag5_q[l], NormBits'(0)}) + DvdW'(den5_q >> 1);
      st_d.lane[l].neg = neg5_q[l];
      st_d.lane[l].rem = dvd[l][DvdW-1 -: MagW];
      st_d.lane[l].lq  = dvd[l][QuotW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      for (int l = 0; l < Lanes; l++) begin
        mag4_q[l] <= mag_d[l];
        neg4_q[l] <= side_q[l][MixW-1];
      end
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
      den5_q <= den_d;
      st_q   <= st_d;
    end
  end

  assign valid_o = v6_q;
  assign data_o  = st_q;

  a_den_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (den5_q >= mag5_q[LaneLeft] && den5_q >= mag5_q[LaneRight]
              && den5_q >= DenMin))
    else $error("divisor below a wheel magnitude or below full scale");

endmodule

// ===== rtl/adm_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, both wheel lanes
// depends on adm_pkg

module adm_div import adm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  div_state_t data_i,
  output logic       valid_o,
  output div_state_t data_o
);

  div_state_t st_in[QuotW];
  div_state_t st_d [QuotW];
  div_state_t st_q [QuotW];
  logic       v_in [QuotW];
  logic       v_q  [QuotW];

  function automatic div_lane_t div_step(div_lane_t x, logic [MagW-1:0] den);
    logic [MagW:0] sh;
    logic [MagW:0] diff;
    div_lane_t     y;
    sh    = {x.rem, x.lq[QuotW-1]};
    diff  = sh - {1'b0, den};
    y.neg = x.neg;
    if (sh >= {1'b0, den}) begin
      y.rem = diff[MagW-1:0];
      y.lq  = {x.lq[QuotW-2:0], 1'b1};
    end else begin
      y.rem = sh[MagW-1:0];
      y.lq  = {x.lq[QuotW-2:0], 1'b0};
    end
    return y;
  endfunction

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign st_in[s] = data_i;
      assign v_in[s]  = valid_i;
    end else begin : g_next
      assign st_in[s] = st_q[s-1];
      assign v_in[s]  = v_q[s-1];
    end

    always_comb begin
      st_d[s].den = st_in[s].den;
      for (int l = 0; l < Lanes; l++) begin
        st_d[s].lane[l] = div_step(st_in[s].lane[l], st_in[s].den);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign valid_o = v_q[QuotW-1];
  assign data_o  = st_q[QuotW-1];

  a_rem_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (data_i.lane[LaneLeft].rem < data_i.den
                 && data_i.lane[LaneRight].rem < data_i.den))
    else $error("initial remainder not below divisor");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QuotW-1] |-> (st_q[QuotW-1].lane[LaneLeft].lq <= QuotMax
                      && st_q[QuotW-1].lane[LaneRight].lq <= QuotMax))
    else $error("normalized power above one");

endmodule

// ===== rtl/adm_curve.sv =====
`timescale 1ns / 1ps
// smoothstep power curve n*n*(3-2n), percent scaling, rounding and sign
// depends on adm_pkg

module adm_curve import adm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  div_state_t data_i,
  output logic       valid_o,
  output out_t       data_o
);

  logic [2*QuotW-1:0] sq     [Lanes];
  logic [N2W-1:0]     n2_d   [Lanes];
  logic [CW-1:0]      c_d    [Lanes];
  logic [N2W-1:0]     n2_q   [Lanes];
  logic [CW-1:0]      c_q    [Lanes];
  logic [N2W+CW-1:0]  pr     [Lanes];
  logic [PolyW-1:0]   poly_d [Lanes];
  logic [PolyW-1:0]   poly_q [Lanes];
  logic [SumW-1:0]    sum_d  [Lanes];
  logic [SumW-1:0]    sum_q  [Lanes];
  logic               neg1_q [Lanes];
  logic               neg2_q [Lanes];
  logic               neg3_q [Lanes];
  logic [OutW-1:0]    mag    [Lanes];
  logic [OutW-1:0]    pw     [Lanes];
  logic               v1_q, v2_q, v3_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      sq[l]     = (2*QuotW)'(data_i.lane[l].lq) * (2*QuotW)'(data_i.lane[l].lq);
      n2_d[l]   = sq[l][N2W-1:0];
      c_d[l]    = CurveK - {data_i.lane[l].lq, 1'b0};
      pr[l]     = (N2W+CW)'(n2_q[l]) * (N2W+CW)'(c_q[l]);
      poly_d[l] = pr[l][PolyW-1:0];
      sum_d[l]  = SumW'(poly_q[l]) * PctScale + RoundVal;
      // only the bits of the 16 bit field survive, also after negation
      mag[l]    = sum_q[l][ShiftAmt +: OutW];
      pw[l]     = neg3_q[l] ? (~mag[l] + OutW'(1)) : mag[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < Lanes; l++) begin
        neg1_q[l] <= data_i.lane[l].neg;
      end
      n2_q   <= n2_d;
      c_q    <= c_d;
      neg2_q <= neg1_q;
      poly_q <= poly_d;
      neg3_q <= neg2_q;
      sum_q  <= sum_d;
    end
  end

  assign valid_o                  = v3_q;
  assign data_o.front_left_power  = pw[LaneLeft];
  assign data_o.front_right_power = pw[LaneRight];
  assign data_o.back_left_power   = pw[LaneLeft];
  assign data_o.back_right_power  = pw[LaneRight];

endmodule

// ===== rtl/adm_outbuf.sv =====
`timescale 1ns / 1ps
// two entry output buffer that decouples the pipeline from the result channel
// depends on adm_pkg

module adm_outbuf import adm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic room_o,
  output logic valid_o,
  input  logic ready_i,
  output out_t data_o
);

  out_t       mem_q[2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign room_o  = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push_i)
    else $error("item pushed into full output buffer");

endmodule

// ===== rtl/arcade_drive_mixer_smoothed.sv =====
`timescale 1ns / 1ps
// arcade drive mixer top level: config registers, pipeline and output buffer
// depends on adm_pkg, adm_smooth, adm_mix, adm_div, adm_curve, adm_outbuf
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    in_data_i (in_t)
//   out      out  out_valid_o / out_ready_i  out_data_o (out_t)
//   cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one item per cycle while the output buffer has room; each item passes through
// 2 smoothing stages, 4 mixing stages, 17 divider stages (one quotient bit
// each), 3 curve stages and the output buffer
// the whole pipeline advances while the two entry output buffer has room,
// so in_ready_o depends on registered state only
// reset empties the pipeline and loads dead zone 5 and both ratings 128

module arcade_drive_mixer_smoothed import adm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [DzW-1:0]   dz_q;
  logic [RateW-1:0] trate_q, frate_q;
  logic             adv;
  logic             sm_valid, mix_valid, div_valid, crv_valid;
  axes_t            sm_data;
  div_state_t       mix_data, div_data;
  out_t             crv_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= DeadZoneRst;
      trate_q <= RatingRst;
      frate_q <= RatingRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDeadZone:   dz_q    <= cfg_data_i[DzW-1:0];
        CfgTurnRating: trate_q <= cfg_data_i[RateW-1:0];
        CfgFwdRating:  frate_q <= cfg_data_i[RateW-1:0];
        default:       ;
      endcase
    end
  end

  adm_smooth u_smooth (
    .clk_i,
    .rst_ni,
    .en_i             (adv),
    .valid_i          (in_valid_i),
    .data_i           (in_data_i),
    .dead_zone_i      (dz_q),
    .turn_rating_i    (trate_q),
    .forward_rating_i (frate_q),
    .valid_o          (sm_valid),
    .data_o           (sm_data)
  );

  adm_mix u_mix (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (sm_valid),
    .data_i  (sm_data),
    .valid_o (mix_valid),
    .data_o  (mix_data)
  );

  adm_div u_div (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (mix_valid),
    .data_i  (mix_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  adm_curve u_curve (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (div_valid),
    .data_i  (div_data),
    .valid_o (crv_valid),
    .data_o  (crv_data)
  );

  adm_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .push_i  (adv && crv_valid),
    .data_i  (crv_data),
    .room_o  (adv),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== test/tb_arcade_drive_mixer_smoothed.sv =====
`timescale 1ns / 1ps
// self-checking testbench for arcade_drive_mixer_smoothed
// depends on adm_pkg and the block's rtl; predicts wheel powers from the register shadow

module tb_arcade_drive_mixer_smoothed;
  import adm_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandItemsPerPhase = 119;
  localparam int unsigned Phases = 8;
  localparam int unsigned MaxReports = 40;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // register shadow, follows accepted writes
  logic [DzW-1:0]   dead_zone_q = DeadZoneRst;
  logic [RateW-1:0] turn_rating_q = RatingRst;
  logic [RateW-1:0] fwd_rating_q = RatingRst;

  in_t  stick_queue[$];
  out_t power_queue[$];
  int unsigned items_queued = 0;
  int unsigned powers_seen = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned sink_stall = 0;
  bit          no_idle = 1'b0;

  string field_names[4] = '{"front_left_power", "front_right_power",
                            "back_left_power", "back_right_power"};

  arcade_drive_mixer_smoothed dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // smoothed axis as a numerator over 5120
  function automatic longint smooth_axis(longint cur, longint old, longint rating);
    longint mag;
    longint k;
    mag = (cur < 0) ? -cur : cur;
    if (mag > longint'(dead_zone_q)) begin
      k = 2048 + 10 * rating;
      return cur * k + old * (5120 - k);
    end
    return old * (1536 - 4 * rating);
  endfunction

  // signed smoothstep, rounded half away from zero
  function automatic logic [OutW-1:0] curve_power(longint x, longint unsigned den);
    longint unsigned a;
    longint unsigned n;
    longint unsigned poly;
    longint unsigned mag;
    a = (x < 0) ? longint'(-x) : longint'(x);
    n = ((a << 16) + den / 2) / den;
    poly = n * n * (64'd196608 - 64'd2 * n);
    mag = (poly * 64'd100 + (64'd1 << (47 - FracBits))) >> (48 - FracBits);
    return (x < 0) ? OutW'(64'd0 - mag) : OutW'(mag);
  endfunction

  function automatic out_t mix_powers(in_t s);
    longint turn_ax;
    longint fwd_ax;
    longint left;
    longint right;
    longint unsigned m;
    longint unsigned den;
    out_t r;
    turn_ax = smooth_axis(longint'(s.turn_now), longint'(s.turn_prev), longint'(turn_rating_q));
    fwd_ax = smooth_axis(longint'(s.forward_now), longint'(s.forward_prev),
                         longint'(fwd_rating_q));
    left = fwd_ax + turn_ax;
    right = fwd_ax - turn_ax;
    m = (left < 0) ? longint'(-left) : longint'(left);
    if (((right < 0) ? -right : right) > longint'(m))
      m = (right < 0) ? longint'(-right) : longint'(right);
    den = 64'd512000;
    if (m > den)
      den = m;
    r.front_left_power = curve_power(left, den);
    r.front_right_power = curve_power(right, den);
    r.back_left_power = r.front_left_power;
    r.back_right_power = r.front_right_power;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int rand_reading();
    int unsigned r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 6) return int'($urandom_range(0, 200)) - 100;
    if (r < 8) return int'($urandom_range(0, 255)) - 128;
    // around the dead zone edge
    v = int'($urandom_range(0, 2 * int'(dead_zone_q) + 4)) - (int'(dead_zone_q) + 2);
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v;
  endfunction

  task automatic push_item(int tn, int tp, int fn, int fp);
    in_t s;
    s.turn_now = InW'(tn);
    s.turn_prev = InW'(tp);
    s.forward_now = InW'(fn);
    s.forward_prev = InW'(fp);
    stick_queue.push_back(s);
    items_queued++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_all_powers();
    while (powers_seen != items_queued) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (stick_queue.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= stick_queue.pop_front();
        send_gap <= no_idle ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0)
          sink_stall <= pick_gap();
      end
    end
  end

  // accepted items and register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        power_queue.push_back(mix_powers(in_data_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgDeadZone:   dead_zone_q <= cfg_data_i[DzW-1:0];
          CfgTurnRating: turn_rating_q <= cfg_data_i[RateW-1:0];
          CfgFwdRating:  fwd_rating_q <= cfg_data_i[RateW-1:0];
          default: ;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (power_queue.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t: unexpected item, expected none, got %h", $time, got);
      end else begin
        want = power_queue.pop_front();
        powers_seen++;
        for (int i = 0; i < 4; i++) begin
          if (got[63-16*i -: 16] !== want[63-16*i -: 16]) begin
            err_count++;
            if (err_count <= MaxReports)
              $display("%0t: %s expected %0d, got %0d", $time, field_names[i],
                       $signed(want[63-16*i -: 16]), $signed(got[63-16*i -: 16]));
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] dz_w;
    logic [CfgDataW-1:0] tr_w;
    logic [CfgDataW-1:0] fr_w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items under reset settings
    push_item(0, 0, 0, 0);
    push_item(100, 100, 100, 100);
    push_item(-100, -100, -100, -100);
    push_item(127, 127, 127, 127);
    push_item(-128, -128, -128, -128);
    push_item(100, -100, 0, 0);
    push_item(0, 0, 100, -100);
    push_item(60, 60, 60, 60);          // right side cancels to zero
    push_item(-60, -60, 60, 60);        // left side cancels to zero
    push_item(5, 100, 5, -100);         // both axes on the dead zone edge
    push_item(6, 100, 6, -100);         // just outside it
    push_item(-5, -100, -6, 100);
    push_item(-128, 127, 127, -128);    // readings beyond 100
    push_item(1, 0, -1, 0);
    push_item(100, -100, -100, 100);
    push_item(0, -128, 0, 127);
    wait_all_powers();

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin dz_w = 9'd0;   tr_w = 9'd0;   fr_w = 9'd0;   end
        1: begin dz_w = 9'd127; tr_w = 9'd511; fr_w = 9'd511; end
        2: begin dz_w = 9'd100; tr_w = 9'd256; fr_w = 9'd256; end
        4: begin dz_w = CfgDataW'(DeadZoneRst); tr_w = RatingRst; fr_w = RatingRst; end
        5: begin
          dz_w = CfgDataW'($urandom_range(0, 20));
          tr_w = CfgDataW'($urandom_range(0, 256));
          fr_w = CfgDataW'($urandom_range(0, 256));
        end
        6: begin dz_w = 9'd127; tr_w = 9'd0;   fr_w = 9'd511; end
        default: begin
          dz_w = CfgDataW'($urandom);
          tr_w = CfgDataW'($urandom);
          fr_w = CfgDataW'($urandom);
        end
      endcase
      write_reg(CfgDeadZone, dz_w);
      write_reg(CfgTurnRating, tr_w);
      write_reg(CfgFwdRating, fr_w);
      write_reg(CfgUnused, CfgDataW'($urandom));  // must leave the settings alone
      no_idle = (p % 3 == 1);
      for (int i = 0; i < RandItemsPerPhase; i++)
        push_item(rand_reading(), rand_reading(), rand_reading(), rand_reading());
      // sender holds off until every power of the phase is back
      wait_all_powers();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
